// ----- hw/rtl/dad_pkg.sv -----
// Shared types and constants for the Gregorian date adder.
// Holds the sequencer states, the arithmetic unit opcodes and the month length table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dad_pkg;

  // Width of the running day count and of the arithmetic unit
  localparam int unsigned DAD_ACC_W = 16;
  // Year counter is one bit wider than the port; leap years follow the 400-year residue
  localparam int unsigned DAD_YEAR_W = 15;
  // Residue of the year within the 400-year Gregorian cycle
  localparam int unsigned DAD_CYC_W = 9;
  localparam logic [DAD_CYC_W-1:0] DAD_YEAR_CYCLE = 9'd400;
  localparam logic [DAD_CYC_W-1:0] DAD_CENTURY_1 = 9'd100;
  localparam logic [DAD_CYC_W-1:0] DAD_CENTURY_2 = 9'd200;
  localparam logic [DAD_CYC_W-1:0] DAD_CENTURY_3 = 9'd300;
  localparam logic [DAD_CYC_W-1:0] DAD_CYCLE_LAST = 9'd399;
  // Shift of the first reduction step: 400 << 5 is the largest power-of-two multiple of 400 below 2^14
  localparam logic [2:0] DAD_MOD_TOP = 3'd5;
  localparam logic [3:0] DAD_JAN = 4'd1;
  localparam logic [3:0] DAD_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SUM,
    ST_WALK,
    ST_OUT
  } dad_state_e;

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } dad_op_e;

  // Length of a month; zero outside January to December
  function automatic logic [4:0] dad_month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    begin
      case (month)
        4'd1:    len = 5'd31;
        4'd2:    len = leap ? 5'd29 : 5'd28;
        4'd3:    len = 5'd31;
        4'd4:    len = 5'd30;
        4'd5:    len = 5'd31;
        4'd6:    len = 5'd30;
        4'd7:    len = 5'd31;
        4'd8:    len = 5'd31;
        4'd9:    len = 5'd30;
        4'd10:   len = 5'd31;
        4'd11:   len = 5'd30;
        4'd12:   len = 5'd31;
        default: len = 5'd0;
      endcase
      return len;
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dad_alu.sv -----
// Shared add/subtract unit of the date adder.
// Depends on dad_pkg for the operand width and opcodes.
`timescale 1ns / 1ps
`default_nettype none

module dad_alu (
  input  wire logic [dad_pkg::DAD_ACC_W-1:0] a_i,
  input  wire logic [dad_pkg::DAD_ACC_W-1:0] b_i,
  input  wire dad_pkg::dad_op_e              op_i,
  output logic      [dad_pkg::DAD_ACC_W-1:0] res_o,
  output logic                               carry_o
);
  import dad_pkg::*;

  logic              is_sub;
  logic [DAD_ACC_W-1:0] b_eff;
  logic [DAD_ACC_W:0]   sum;

  // Subtract as add of the inverted operand plus one; carry high means no borrow
  assign is_sub  = (op_i == OP_SUB);
  assign b_eff   = is_sub ? ~b_i : b_i;
  assign sum     = {1'b0, a_i} + {1'b0, b_eff} + {{DAD_ACC_W{1'b0}}, is_sub};
  assign res_o   = sum[DAD_ACC_W-1:0];
  assign carry_o = sum[DAD_ACC_W];

endmodule

`default_nettype wire

// ----- hw/rtl/date_add_days.sv -----
// Gregorian date plus a count of days: one request gives one resulting date.
// A request first reduces the year within the 400-year cycle, then adds the lengths of the
// months before start_month and then the day, then walks the count month by month from
// January, and then presents the result. The reduction, sums and walk use the single shared
// adder/subtractor in dad_alu, and the block takes no new request until the result has
// been taken. Years past 16383 wrap on result_year_o while leap years follow the full count.
// Depends on dad_pkg and dad_alu.
`timescale 1ns / 1ps
`default_nettype none

module date_add_days (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [13:0] start_year_i,
  input  wire logic [3:0]  start_month_i,
  input  wire logic [4:0]  start_day_i,
  input  wire logic [14:0] days_to_add_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [13:0] result_year_o,
  output logic      [3:0]  result_month_o,
  output logic      [4:0]  result_day_o
);
  import dad_pkg::*;

  dad_state_e           state_q, state_d;
  logic [DAD_ACC_W-1:0] acc_q, acc_d;
  logic [DAD_YEAR_W-1:0] year_q, year_d;
  logic [DAD_CYC_W-1:0] cyc_q, cyc_d;
  logic [3:0]           m_q, m_d;
  logic [2:0]           k_q, k_d;
  logic [3:0]           month_q, month_d;
  logic [4:0]           day_q, day_d;
  logic [14:0]          add_q, add_d;

  logic                 leap;
  logic [4:0]           len;
  logic [DAD_ACC_W-1:0] alu_b;
  dad_op_e              alu_op;
  logic [DAD_ACC_W-1:0] alu_res;
  logic                 alu_carry;
  logic                 accept;

  // Leap year from the residue within the 400-year cycle
  assign leap = (cyc_q == '0) ||
                ((cyc_q[1:0] == 2'b00) && (cyc_q != DAD_CENTURY_1) &&
                 (cyc_q != DAD_CENTURY_2) && (cyc_q != DAD_CENTURY_3));
  assign len  = dad_month_len(m_q, leap);

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  // Hold the result straight from the working registers
  assign result_year_o  = year_q[13:0];
  assign result_month_o = m_q;
  assign result_day_o   = acc_q[4:0];

  // Select the second operand and the operation of the shared unit
  always_comb begin
    alu_op = OP_SUB;
    alu_b  = {{(DAD_ACC_W-5){1'b0}}, len};
    case (state_q)
      ST_MOD: begin
        alu_b = {{(DAD_ACC_W-DAD_CYC_W){1'b0}}, DAD_YEAR_CYCLE} << k_q;
      end
      ST_SUM: begin
        alu_op = OP_ADD;
        if (!((m_q < month_q) && (m_q <= DAD_DEC))) begin
          alu_b = {{(DAD_ACC_W-5){1'b0}}, day_q};
        end
      end
      default: begin
        alu_op = OP_SUB;
      end
    endcase
  end

  dad_alu u_alu (
    .a_i     (acc_q),
    .b_i     (alu_b),
    .op_i    (alu_op),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  // Sequence one request through the shared unit
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    year_d  = year_q;
    cyc_d   = cyc_q;
    m_d     = m_q;
    k_d     = k_q;
    month_d = month_q;
    day_d   = day_q;
    add_d   = add_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          acc_d   = {{(DAD_ACC_W-14){1'b0}}, start_year_i};
          year_d  = {1'b0, start_year_i};
          month_d = start_month_i;
          day_d   = start_day_i;
          add_d   = days_to_add_i;
          k_d     = DAD_MOD_TOP;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        // Restoring reduction of the year by 400 << k
        if (k_q == '0) begin
          cyc_d   = alu_carry ? alu_res[DAD_CYC_W-1:0] : acc_q[DAD_CYC_W-1:0];
          acc_d   = {{(DAD_ACC_W-15){1'b0}}, add_q};
          m_d     = DAD_JAN;
          state_d = ST_SUM;
        end else begin
          if (alu_carry) begin
            acc_d = alu_res;
          end
          k_d = k_q - 3'd1;
        end
      end
      ST_SUM: begin
        // Add the months before the start month, then the day
        acc_d = alu_res;
        if ((m_q < month_q) && (m_q <= DAD_DEC)) begin
          m_d = m_q + 4'd1;
        end else begin
          m_d     = DAD_JAN;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        // Drop a whole month while the count exceeds it
        if (alu_carry && (alu_res != '0)) begin
          acc_d = alu_res;
          if (m_q == DAD_DEC) begin
            m_d    = DAD_JAN;
            year_d = year_q + 15'd1;
            cyc_d  = (cyc_q == DAD_CYCLE_LAST) ? '0 : cyc_q + 9'd1;
          end else begin
            m_d = m_q + 4'd1;
          end
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    year_q  <= year_d;
    cyc_q   <= cyc_d;
    m_q     <= m_d;
    k_q     <= k_d;
    month_q <= month_d;
    day_q   <= day_d;
    add_q   <= add_d;
  end

`ifndef SYNTH
  a_stall_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_MOD) && (k_q == DAD_MOD_TOP))
    else $error("accepted request did not start the year reduction");

  a_cyc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (cyc_q <= DAD_CYCLE_LAST))
    else $error("year residue out of the 400-year cycle");

  a_walk_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_OUT) |-> (m_q >= DAD_JAN && m_q <= DAD_DEC))
    else $error("walk month out of range");

  a_day_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (acc_q <= {{(DAD_ACC_W-5){1'b0}}, len}))
    else $error("result day exceeds its month");
`endif

endmodule

`default_nettype wire

// ----- test/date_add_days_tb.sv -----
// Self-checking testbench for the Gregorian date adder date_add_days.
// Holds a date predictor with a result store, plus drivers for the request and result channels.
// Depends on date_add_days from hw/rtl, and through it on dad_pkg.
`timescale 1ns / 1ps

package date_add_days_tb_pkg;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } calendar_date_t;

  // Predict each accepted request and hold the dates still due from the block
  class date_checker;
    calendar_date_t due_dates[$];
    int unsigned    requests;
    int unsigned    dates_checked;
    int unsigned    mismatches;
    int unsigned    late_years;
    int unsigned    leap_days;

    static function bit is_leap(int unsigned yr);
      return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    endfunction

    // Months outside January to December count as empty
    static function int unsigned month_days(int unsigned yr, int unsigned mon);
      case (mon)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        2:                     return is_leap(yr) ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    // Count the ordinal from January, then walk it forward month by month
    function calendar_date_t add_days_to_date(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                                              logic [14:0] a);
      int unsigned    yr;
      int unsigned    mon;
      int unsigned    ordinal;
      calendar_date_t res;
      yr = y;
      ordinal = 0;
      for (mon = 1; mon < m; mon++) ordinal += month_days(yr, mon);
      ordinal += int'(d) + int'(a);
      mon = 1;
      while (ordinal > month_days(yr, mon)) begin
        ordinal -= month_days(yr, mon);
        mon++;
        if (mon > 12) begin
          mon = 1;
          yr++;
        end
      end
      if (yr > 9999) late_years++;
      res.year  = yr[13:0];
      res.month = mon[3:0];
      res.day   = ordinal[4:0];
      return res;
    endfunction

    function void note_request(logic [13:0] y, logic [3:0] m, logic [4:0] d, logic [14:0] a);
      due_dates.push_back(add_days_to_date(y, m, d, a));
      requests++;
    endfunction

    function int unsigned pending();
      return due_dates.size();
    endfunction

    function void check_result(logic [13:0] y, logic [3:0] m, logic [4:0] d);
      calendar_date_t want;
      if (due_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("date_checker: result %0d-%0d-%0d arrived with no request outstanding",
                   y, m, d);
        return;
      end
      want = due_dates.pop_front();
      dates_checked++;
      if (want.year !== y || want.month !== m || want.day !== d) begin
        mismatches++;
        if (mismatches <= 10)
          $display("date_checker: expected %0d-%0d-%0d, got %0d-%0d-%0d",
                   want.year, want.month, want.day, y, m, d);
      end else if (m == 4'd2 && d == 5'd29) begin
        leap_days++;
      end
    endfunction
  endclass

endpackage

module date_add_days_tb;
  import date_add_days_tb_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [13:0] start_year_i = '0;
  logic [3:0]  start_month_i = '0;
  logic [4:0]  start_day_i = '0;
  logic [14:0] days_to_add_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [13:0] result_year_o;
  logic [3:0]  result_month_o;
  logic [4:0]  result_day_o;

  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 78;
  date_checker dates_due;

  date_add_days dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_year_i   (start_year_i),
    .start_month_i  (start_month_i),
    .start_day_i    (start_day_i),
    .days_to_add_i  (days_to_add_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_year_o  (result_year_o),
    .result_month_o (result_month_o),
    .result_day_o   (result_day_o)
  );

  always #4 clk_i = ~clk_i;

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Check every result taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      dates_due.check_result(result_year_o, result_month_o, result_day_o);
  end

  // Offer one request, idling first at random, and hold it until taken
  task automatic send_request(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d,
                              input logic [14:0] a);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    start_year_i  <= y;
    start_month_i <= m;
    start_day_i   <= d;
    days_to_add_i <= a;
    do @(posedge clk_i); while (in_stall_o);
    dates_due.note_request(y, m, d, a);
    @(negedge clk_i);
  endtask

  // Hold off new requests until every due date has come back
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (dates_due.pending() != 0) @(negedge clk_i);
  endtask

  // Mostly valid dates with short spans; a few malformed fields and long spans
  task automatic send_random_date();
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [14:0] a;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 82) begin
      y = 14'($urandom_range(1, 9999));
      m = 4'($urandom_range(1, 12));
      d = 5'($urandom_range(1, date_checker::month_days(y, m)));
    end else if (pick < 88) begin
      y = 14'($urandom_range(16000, 16383));
      m = 4'($urandom_range(1, 12));
      d = 5'($urandom_range(1, date_checker::month_days(y, m)));
    end else begin
      y = 14'($urandom_range(0, 16383));
      m = 4'($urandom_range(0, 15));
      d = 5'($urandom_range(0, 31));
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) a = 15'($urandom_range(0, 400));
    else if (pick < 88) a = 15'($urandom_range(0, 4000));
    else a = 15'($urandom_range(0, 32767));
    send_request(y, m, d, a);
  endtask

  initial begin
    dates_due = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed edge dates
    send_request(14'd1,     4'd1,  5'd1,  15'd0);
    send_request(14'd2024,  4'd2,  5'd28, 15'd1);
    send_request(14'd2023,  4'd2,  5'd28, 15'd1);
    send_request(14'd1900,  4'd2,  5'd28, 15'd1);
    send_request(14'd2000,  4'd2,  5'd28, 15'd1);
    send_request(14'd2100,  4'd2,  5'd29, 15'd0);
    send_request(14'd2023,  4'd12, 5'd31, 15'd1);
    send_request(14'd9999,  4'd12, 5'd31, 15'd32767);
    send_request(14'd0,     4'd2,  5'd28, 15'd1);
    send_request(14'd77,    4'd0,  5'd5,  15'd0);
    send_request(14'd1999,  4'd13, 5'd1,  15'd0);
    send_request(14'd2000,  4'd15, 5'd31, 15'd0);
    send_request(14'd2021,  4'd2,  5'd31, 15'd0);
    send_request(14'd2021,  4'd4,  5'd31, 15'd3);
    send_request(14'd5,     4'd1,  5'd0,  15'd0);
    send_request(14'd6,     4'd0,  5'd0,  15'd0);
    send_request(14'd16383, 4'd12, 5'd31, 15'd1);
    send_request(14'd16383, 4'd1,  5'd1,  15'd32767);
    send_request(14'd16383, 4'd15, 5'd31, 15'd32767);
    send_request(14'd0,     4'd0,  5'd0,  15'd0);
    send_request(14'd8192,  4'd8,  5'd16, 15'd16384);
    send_request(14'd2400,  4'd1,  5'd31, 15'd29);
    drain_requests();

    // Sender mostly busy, receiver mostly stalling
    repeat (180) send_random_date();
    drain_requests();

    // Sender mostly idle, receiver mostly ready
    send_idle_pct = 78;
    recv_idle_pct = 26;
    repeat (180) send_random_date();
    drain_requests();

    // Back to back, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (180) send_random_date();
    drain_requests();
    repeat (40) @(posedge clk_i);

    $display("Run covered %0d requests over three idling mixes plus directed edge dates;",
             dates_due.requests);
    $display("%0d dates checked, %0d past year 9999, %0d landing on 29 February.",
             dates_due.dates_checked, dates_due.late_years, dates_due.leap_days);
    if (dates_due.mismatches == 0 && dates_due.pending() == 0) begin
      $display("date_add_days_tb passed");
    end else begin
      $display("date_add_days_tb failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #30000000;
    $display("date_add_days_tb failed");
    $finish;
  end

endmodule
